@@ rtl/core/lrdq_pkg.sv @@
// ----------------------------------------------------------------------------
// lrdq_pkg
// Shared sizes, command and status codes and the link word layout of the
// locked ready deque bank.
// ----------------------------------------------------------------------------
package lrdq_pkg;

  localparam int NUM_WORKERS = 16;
  localparam int NUM_HANDLES = 1024;
  localparam int WORKER_W    = $clog2(NUM_WORKERS);
  localparam int HANDLE_W    = $clog2(NUM_HANDLES);

  // command codes; the two codes above unlock do nothing
  typedef enum logic [2:0] {
    CMD_PUSH_BOT = 3'd0,
    CMD_POP_TOP  = 3'd1,
    CMD_POP_BOT  = 3'd2,
    CMD_PEEK     = 3'd3,
    CMD_TRY_LOCK = 3'd4,
    CMD_UNLOCK   = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_OWNER = 3'd2,
    ST_QUEUED    = 3'd3,
    ST_LOCK_BUSY = 3'd4
  } status_e;

  // per-handle word: back link plus queued flag
  typedef struct packed {
    logic [HANDLE_W-1:0] prev;
    logic                queued;
  } plink_t;

endpackage

@@ rtl/core/lrdq_ram.sv @@
// ----------------------------------------------------------------------------
// lrdq_ram
// Simple dual-port synchronous RAM, one write and one read port, read data
// registered.
// ----------------------------------------------------------------------------
module lrdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/locked_ready_deque_bank_unit.sv @@
// ----------------------------------------------------------------------------
// locked_ready_deque_bank_unit
// Bank of per-worker ready deques kept as doubly linked lists of task handles.
// An item is taken only while idle: the link RAM read is issued in the accept
// cycle, then the update and write-back are done in the execute state, and
// done_o and the result outputs are registered from it; busy stays high until
// the item is through. Reset clears all heads and locks, then a clearing pass
// over all NUM_HANDLES (1024) handles marks every handle unqueued while busy is
// high. Results are strobed on done_o for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module locked_ready_deque_bank_unit
  import lrdq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          command_i,
  input  logic [WORKER_W-1:0] deque_index_i,
  input  logic [WORKER_W-1:0] requester_worker_i,
  input  logic [HANDLE_W-1:0] handle_i,
  output logic                done_o,
  output logic [HANDLE_W-1:0] result_handle_o,
  output logic                result_valid_o,
  output logic [2:0]          status_o,
  output logic [HANDLE_W-1:0] top_handle_o,
  output logic [HANDLE_W-1:0] bottom_handle_o,
  output logic                deque_nonempty_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   accept;

  // per-deque head state
  logic [HANDLE_W-1:0] top_q   [NUM_WORKERS];
  logic [HANDLE_W-1:0] bot_q   [NUM_WORKERS];
  logic                ne_q    [NUM_WORKERS];
  logic                lk_q    [NUM_WORKERS];
  logic [WORKER_W-1:0] own_q   [NUM_WORKERS];

  // item captured at accept, with the addressed deque's head state
  logic [2:0]          cmd_q;
  logic [WORKER_W-1:0] d_q;
  logic [WORKER_W-1:0] who_q;
  logic [HANDLE_W-1:0] h_q;
  logic [HANDLE_W-1:0] t_q;
  logic [HANDLE_W-1:0] b_q;
  logic                nes_q;
  logic                lks_q;
  logic [WORKER_W-1:0] owns_q;

  logic [HANDLE_W-1:0] clr_q;

  // RAM ports
  logic                na_we;
  logic [HANDLE_W-1:0] na_waddr;
  logic [HANDLE_W-1:0] na_wdata;
  logic [HANDLE_W-1:0] na_raddr;
  logic [HANDLE_W-1:0] na_rdata;
  logic                pb_we;
  logic [HANDLE_W-1:0] pb_waddr;
  plink_t              pb_wdata;
  logic [HANDLE_W-1:0] pb_raddr;
  plink_t              pb_rdata;

  // update computed in the execute cycle
  logic [HANDLE_W-1:0] top_n;
  logic [HANDLE_W-1:0] bot_n;
  logic                ne_n;
  logic                lk_n;
  logic [WORKER_W-1:0] own_n;
  logic [HANDLE_W-1:0] res_n;
  logic                vld_n;
  status_e             st_n;
  logic                owner;
  logic                ex_we;
  logic                ex_na_we;
  logic [HANDLE_W-1:0] ex_pb_addr;
  plink_t              ex_pb_data;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // forward links: next handle toward the bottom
  lrdq_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (NUM_HANDLES)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (na_we),
    .waddr_i (na_waddr),
    .wdata_i (na_wdata),
    .raddr_i (na_raddr),
    .rdata_o (na_rdata)
  );

  // back links and queued flags
  lrdq_ram #(
    .WIDTH ($bits(plink_t)),
    .DEPTH (NUM_HANDLES)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (pb_we),
    .waddr_i (pb_waddr),
    .wdata_i (pb_wdata),
    .raddr_i (pb_raddr),
    .rdata_o (pb_rdata)
  );

  // read addresses are issued in the accept cycle
  assign na_raddr = top_q[deque_index_i];
  assign pb_raddr = (command_i == CMD_PUSH_BOT) ? handle_i : bot_q[deque_index_i];

  // execute: decide the update from captured heads and RAM read data
  always_comb begin
    owner      = lks_q && (owns_q == who_q);
    top_n      = t_q;
    bot_n      = b_q;
    ne_n       = nes_q;
    lk_n       = lks_q;
    own_n      = owns_q;
    res_n      = '0;
    vld_n      = 1'b0;
    st_n       = ST_OK;
    ex_we      = 1'b0;
    ex_na_we   = 1'b0;
    ex_pb_addr = h_q;
    ex_pb_data = '{prev: b_q, queued: 1'b1};
    unique case (cmd_q)
      CMD_PUSH_BOT: begin
        if (!owner) begin
          st_n = ST_NOT_OWNER;
        end else if (pb_rdata.queued) begin
          st_n = ST_QUEUED;
        end else begin
          ex_we    = 1'b1;
          ex_na_we = nes_q;
          if (!nes_q) begin
            top_n = h_q;
            ne_n  = 1'b1;
          end
          bot_n = h_q;
        end
      end
      CMD_POP_TOP: begin
        if (!owner) begin
          st_n = ST_NOT_OWNER;
        end else if (!nes_q) begin
          st_n = ST_EMPTY;
        end else begin
          res_n      = t_q;
          vld_n      = 1'b1;
          ex_we      = 1'b1;
          ex_pb_addr = t_q;
          ex_pb_data = '{prev: '0, queued: 1'b0};
          if (t_q == b_q) begin
            ne_n = 1'b0;
          end else begin
            top_n = na_rdata;
          end
        end
      end
      CMD_POP_BOT: begin
        if (!owner) begin
          st_n = ST_NOT_OWNER;
        end else if (!nes_q) begin
          st_n = ST_EMPTY;
        end else begin
          res_n      = b_q;
          vld_n      = 1'b1;
          ex_we      = 1'b1;
          ex_pb_addr = b_q;
          ex_pb_data = '{prev: '0, queued: 1'b0};
          if (t_q == b_q) begin
            ne_n = 1'b0;
          end else begin
            bot_n = pb_rdata.prev;
          end
        end
      end
      CMD_PEEK: begin
        if (!owner) begin
          st_n = ST_NOT_OWNER;
        end else if (!nes_q) begin
          st_n = ST_EMPTY;
        end else begin
          res_n = t_q;
          vld_n = 1'b1;
        end
      end
      CMD_TRY_LOCK: begin
        if (lks_q) begin
          st_n = ST_LOCK_BUSY;
        end else begin
          lk_n  = 1'b1;
          own_n = who_q;
        end
      end
      CMD_UNLOCK: begin
        if (!owner) begin
          st_n = ST_NOT_OWNER;
        end else begin
          lk_n  = 1'b0;
          own_n = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // RAM write muxing: clearing pass or execute write-back
  always_comb begin
    na_we    = (state_q == S_EXEC) && ex_na_we;
    na_waddr = b_q;
    na_wdata = h_q;
    if (state_q == S_CLEAR) begin
      pb_we    = 1'b1;
      pb_waddr = clr_q;
      pb_wdata = '{prev: '0, queued: 1'b0};
    end else begin
      pb_we    = (state_q == S_EXEC) && ex_we;
      pb_waddr = ex_pb_addr;
      pb_wdata = ex_pb_data;
    end
  end

  // capture of the accepted item and its deque's head state
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= command_i;
      d_q    <= deque_index_i;
      who_q  <= requester_worker_i;
      h_q    <= handle_i;
      t_q    <= top_q[deque_index_i];
      b_q    <= bot_q[deque_index_i];
      nes_q  <= ne_q[deque_index_i];
      lks_q  <= lk_q[deque_index_i];
      owns_q <= own_q[deque_index_i];
    end
  end

  // sequencer, head registers and result outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_CLEAR;
      clr_q            <= '0;
      done_o           <= 1'b0;
      result_handle_o  <= '0;
      result_valid_o   <= 1'b0;
      status_o         <= '0;
      top_handle_o     <= '0;
      bottom_handle_o  <= '0;
      deque_nonempty_o <= 1'b0;
      for (int i = 0; i < NUM_WORKERS; i++) begin
        top_q[i] <= '0;
        bot_q[i] <= '0;
        ne_q[i]  <= 1'b0;
        lk_q[i]  <= 1'b0;
        own_q[i] <= '0;
      end
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == HANDLE_W'(NUM_HANDLES - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q          <= S_IDLE;
          top_q[d_q]       <= top_n;
          bot_q[d_q]       <= bot_n;
          ne_q[d_q]        <= ne_n;
          lk_q[d_q]        <= lk_n;
          own_q[d_q]       <= own_n;
          done_o           <= 1'b1;
          result_handle_o  <= res_n;
          result_valid_o   <= vld_n;
          status_o         <= st_n;
          top_handle_o     <= ne_n ? top_n : '0;
          bottom_handle_o  <= ne_n ? bot_n : '0;
          deque_nonempty_o <= ne_n;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
